>>> hw/rtl/depth_histogram_colorizer_defines.svh
// assertion macros shared by the colorizer rtl
`ifndef DEPTH_HISTOGRAM_COLORIZER_DEFINES_SVH
`define DEPTH_HISTOGRAM_COLORIZER_DEFINES_SVH
`ifndef ASSERT_OFF
`define DHC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("check failed");
`define DHC_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error("check failed");
`else
`define DHC_ASSERT(lbl, clk, rst, prop)
`define DHC_NEVER(lbl, clk, rst, cond)
`endif
`endif

>>> hw/rtl/dhc_pkg.sv
// shared types and constants of the depth histogram colorizer
`default_nettype none
package dhc_pkg;
   localparam int DEPTH_BITS = 16;
   localparam int COUNT_BITS = 20;
   localparam int IN_BITS    = 16;
   localparam int LIMIT_BITS = 17;
   localparam int LEVEL_BITS = 8;
   localparam int NUM_BITS   = COUNT_BITS + LEVEL_BITS;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = 8'd255;
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 17'h10000;

   typedef enum logic [1:0] {
      REQ_ACCUMULATE = 2'd0,
      REQ_FINALIZE   = 2'd1,
      REQ_MAP        = 2'd2,
      REQ_CLEAR      = 2'd3
   } req_code_type;

   typedef enum logic [2:0] {
      OP_NONE, OP_ACC, OP_FIN, OP_MAP, OP_MAPZ, OP_CLR
   } op_type;

   typedef enum logic [2:0] {
      ST_INIT, ST_IDLE, ST_ACC_WR, ST_FIN, ST_MAP_RD, ST_MAP_DIV, ST_CLR
   } state_type;

   typedef struct packed {
      op_type                op;
      logic [DEPTH_BITS-1:0] addr;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } head_type;

   typedef struct packed {
      logic init_busy;
   } back_status_type;

   function automatic logic in_table(input logic [IN_BITS-1:0] d);
      logic [IN_BITS:0] wide;
      wide = {1'b0, d};
      return (wide >> DEPTH_BITS) == '0;
   endfunction
endpackage
`default_nettype wire

>>> hw/rtl/depth_histogram_colorizer.sv
// top level of the depth histogram colorizer
//
//  channel   ports                               handshake
//  request   start busy req_type req_depth_value  start & !busy
//  result    rsp_valid rsp_level                  one-cycle strobe, no stall
//  config    psel penable pwrite paddr pwdata     apb write, pready tied high
//
// accumulate in the back end reads the store bin, then writes it back
// map reads the store, then runs 8 serial quotient steps when a division is needed
// finalize walks the whole store, one bin per cycle
// clear walks the store the same way
// after reset a clearing pass over the whole store holds busy high
// a two-entry queue lets the front take transactions while the back works
`default_nettype none
module depth_histogram_colorizer (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              start,
   output logic                             busy,
   input  wire  [1:0]                       req_type,
   input  wire  [dhc_pkg::IN_BITS-1:0]      req_depth_value,
   output logic                             rsp_valid,
   output logic [dhc_pkg::LEVEL_BITS-1:0]   rsp_level,
   input  wire                              psel,
   input  wire                              penable,
   input  wire                              pwrite,
   input  wire  [2:0]                       paddr,
   input  wire  [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);
   logic [dhc_pkg::LIMIT_BITS-1:0] depth_limit_ff, depth_limit_in;
   dhc_pkg::head_type        head;
   dhc_pkg::back_status_type status;
   logic                     pop;

   // depth limit register, word at addresses zero to three (only paddr[2] is decoded)
   always_comb begin
      depth_limit_in = depth_limit_ff;
      if (psel && penable && pwrite && !paddr[2])
         depth_limit_in = pwdata[dhc_pkg::LIMIT_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) depth_limit_ff <= dhc_pkg::LIMIT_RESET;
      else       depth_limit_ff <= depth_limit_in;
   end

   assign pready = 1'b1;
   assign prdata = paddr[2] ? '0 : {{(32-dhc_pkg::LIMIT_BITS){1'b0}}, depth_limit_ff};

   // front: classify each transaction and queue the ones that carry an operation
   dhc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_depth_value (req_depth_value),
      .depth_limit     (depth_limit_ff),
      .status          (status),
      .pop             (pop),
      .head            (head)
   );

   // back: histogram store, sweeps and level math
   dhc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_level (rsp_level)
   );
endmodule
`default_nettype wire

>>> hw/rtl/dhc_front.sv
// request classification and the two-entry queue to the back end
`default_nettype none
`include "depth_histogram_colorizer_defines.svh"
module dhc_front (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              start,
   output logic                             busy,
   input  wire  [1:0]                       req_type,
   input  wire  [dhc_pkg::IN_BITS-1:0]      req_depth_value,
   input  wire  [dhc_pkg::LIMIT_BITS-1:0]   depth_limit,
   input  wire  dhc_pkg::back_status_type   status,
   input  wire                              pop,
   output dhc_pkg::head_type                head
);
   dhc_pkg::entry_type entries_ff [2];
   logic [1:0] count_ff, count_in;
   logic       wp_ff, wp_in, rp_ff, rp_in;
   dhc_pkg::op_type op;
   logic push, full;

   always_comb begin
      op = dhc_pkg::OP_NONE;
      unique case (dhc_pkg::req_code_type'(req_type))
         dhc_pkg::REQ_ACCUMULATE: begin
            if (req_depth_value != '0 && {1'b0, req_depth_value} < depth_limit &&
                dhc_pkg::in_table(req_depth_value))
               op = dhc_pkg::OP_ACC;
         end
         dhc_pkg::REQ_FINALIZE: op = dhc_pkg::OP_FIN;
         dhc_pkg::REQ_MAP: op = dhc_pkg::in_table(req_depth_value) ?
                                dhc_pkg::OP_MAP : dhc_pkg::OP_MAPZ;
         dhc_pkg::REQ_CLEAR: op = dhc_pkg::OP_CLR;
         default: op = dhc_pkg::OP_NONE;
      endcase
   end

   assign full = count_ff == 2'd2;
   assign busy = full || status.init_busy;
   assign push = start && !busy && op != dhc_pkg::OP_NONE;
   assign head.valid = count_ff != 2'd0;
   assign head.entry = entries_ff[rp_ff];

   always_comb begin
      wp_in    = push ? ~wp_ff : wp_ff;
      rp_in    = (pop && head.valid) ? ~rp_ff : rp_ff;
      count_in = count_ff + 2'(push) - 2'(pop && head.valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         wp_ff    <= 1'b0;
         rp_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
      end
      if (push) begin
         entries_ff[wp_ff].op   <= op;
         entries_ff[wp_ff].addr <= req_depth_value[dhc_pkg::DEPTH_BITS-1:0];
      end
   end

   `DHC_NEVER(a_count_range, clock, reset, count_ff == 2'd3)
   `DHC_NEVER(a_pop_empty, clock, reset, pop && !head.valid)
   `DHC_NEVER(a_push_busy, clock, reset, push && busy)
endmodule
`default_nettype wire

>>> hw/rtl/dhc_back.sv
// histogram store, sweeps and the serial level divider
`default_nettype none
`include "depth_histogram_colorizer_defines.svh"
module dhc_back (
   input  wire                              clock,
   input  wire                              reset,
   input  wire  dhc_pkg::head_type          head,
   output logic                             pop,
   output dhc_pkg::back_status_type         status,
   output logic                             rsp_valid,
   output logic [dhc_pkg::LEVEL_BITS-1:0]   rsp_level
);
   localparam int DB = dhc_pkg::DEPTH_BITS;
   localparam int CB = dhc_pkg::COUNT_BITS;
   localparam int LB = dhc_pkg::LEVEL_BITS;

   logic [CB-1:0] bin_mem [2**DB];
   logic [CB-1:0] rd_data_ff;
   logic          mem_we;
   logic [DB-1:0] mem_waddr, mem_raddr;
   logic [CB-1:0] mem_wdata;

   dhc_pkg::state_type state_ff, state_in;
   logic [DB-1:0] idx_ff, idx_in, wad_ff, wad_in, addr_ff, addr_in;
   logic          pend_ff, pend_in;
   logic [CB-1:0] prev_ff, prev_in, vp_ff, vp_in, rem_ff, rem_in;
   logic [LB-1:0] low_ff, low_in, quo_ff, quo_in;
   logic [2:0]    step_ff, step_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [LB-1:0] rsp_level_ff, rsp_level_in;

   logic [CB:0]       sum, trial;
   logic [CB-1:0]     diff;
   logic [dhc_pkg::NUM_BITS-1:0] num;
   logic              cum_ok, qbit, fin_done;

   always_comb begin
      sum      = {1'b0, rd_data_ff} + {1'b0, prev_ff};
      diff     = vp_ff - rd_data_ff;
      num      = dhc_pkg::NUM_BITS'(dhc_pkg::LEVEL_MAX) * dhc_pkg::NUM_BITS'(diff);
      cum_ok   = rd_data_ff != '0 && vp_ff != '0 && rd_data_ff < vp_ff;
      trial    = {rem_ff, low_ff[LB-1]};
      qbit     = trial >= {1'b0, vp_ff};
      fin_done = pend_ff && (&wad_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dhc_pkg::ST_INIT, dhc_pkg::ST_CLR: if (&idx_ff) state_in = dhc_pkg::ST_IDLE;
         dhc_pkg::ST_IDLE: begin
            if (head.valid) begin
               unique case (head.entry.op)
                  dhc_pkg::OP_ACC: state_in = dhc_pkg::ST_ACC_WR;
                  dhc_pkg::OP_FIN: state_in = dhc_pkg::ST_FIN;
                  dhc_pkg::OP_MAP: state_in = dhc_pkg::ST_MAP_RD;
                  dhc_pkg::OP_CLR: state_in = dhc_pkg::ST_CLR;
                  default:         state_in = dhc_pkg::ST_IDLE;
               endcase
            end
         end
         dhc_pkg::ST_ACC_WR: state_in = dhc_pkg::ST_IDLE;
         dhc_pkg::ST_FIN:    if (fin_done) state_in = dhc_pkg::ST_IDLE;
         dhc_pkg::ST_MAP_RD: state_in = cum_ok ? dhc_pkg::ST_MAP_DIV : dhc_pkg::ST_IDLE;
         dhc_pkg::ST_MAP_DIV: if (step_ff == 3'd7) state_in = dhc_pkg::ST_IDLE;
         default: state_in = dhc_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      pop          = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = idx_ff;
      mem_wdata    = '0;
      mem_raddr    = head.entry.addr;
      idx_in       = idx_ff;
      wad_in       = wad_ff;
      addr_in      = addr_ff;
      pend_in      = 1'b0;
      prev_in      = prev_ff;
      vp_in        = vp_ff;
      rem_in       = rem_ff;
      low_in       = low_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      rsp_valid_in = 1'b0;
      rsp_level_in = rsp_level_ff;
      unique case (state_ff)
         dhc_pkg::ST_INIT, dhc_pkg::ST_CLR: begin
            mem_we = 1'b1;
            idx_in = idx_ff + 1'b1;
            vp_in  = '0;
         end
         dhc_pkg::ST_IDLE: begin
            if (head.valid) begin
               pop     = 1'b1;
               addr_in = head.entry.addr;
               idx_in  = '0;
               prev_in = '0;
               step_in = '0;
               if (head.entry.op == dhc_pkg::OP_MAPZ) begin
                  rsp_valid_in = 1'b1;
                  rsp_level_in = '0;
               end
            end
         end
         dhc_pkg::ST_ACC_WR: begin
            mem_we    = 1'b1;
            mem_waddr = addr_ff;
            mem_wdata = (rd_data_ff == dhc_pkg::COUNT_MAX) ? rd_data_ff : rd_data_ff + 1'b1;
            vp_in     = (vp_ff == dhc_pkg::COUNT_MAX) ? vp_ff : vp_ff + 1'b1;
         end
         dhc_pkg::ST_FIN: begin
            mem_raddr = idx_ff;
            idx_in    = idx_ff + 1'b1;
            wad_in    = idx_ff;
            pend_in   = 1'b1;
            if (pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = wad_ff;
               mem_wdata = sum[CB] ? dhc_pkg::COUNT_MAX : sum[CB-1:0];
               prev_in   = mem_wdata;
            end
         end
         dhc_pkg::ST_MAP_RD: begin
            rem_in = num[dhc_pkg::NUM_BITS-1:LB];
            low_in = num[LB-1:0];
            if (!cum_ok) begin
               rsp_valid_in = 1'b1;
               rsp_level_in = '0;
            end
         end
         dhc_pkg::ST_MAP_DIV: begin
            rem_in  = qbit ? CB'(trial - {1'b0, vp_ff}) : trial[CB-1:0];
            low_in  = {low_ff[LB-2:0], 1'b0};
            quo_in  = {quo_ff[LB-2:0], qbit};
            step_in = step_ff + 1'b1;
            if (step_ff == 3'd7) begin
               rsp_valid_in = 1'b1;
               rsp_level_in = {quo_ff[LB-2:0], qbit};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) bin_mem[mem_waddr] <= mem_wdata;
      rd_data_ff <= bin_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dhc_pkg::ST_INIT;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         vp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         vp_ff        <= vp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      wad_ff       <= wad_in;
      addr_ff      <= addr_in;
      prev_ff      <= prev_in;
      rem_ff       <= rem_in;
      low_ff       <= low_in;
      quo_ff       <= quo_in;
      step_ff      <= step_in;
      rsp_level_ff <= rsp_level_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_level        = rsp_level_ff;
   assign status.init_busy = state_ff == dhc_pkg::ST_INIT;

   `DHC_NEVER(a_no_write_idle, clock, reset, mem_we && state_ff == dhc_pkg::ST_IDLE)
   `DHC_ASSERT(a_rsp_source, clock, reset, rsp_valid_ff |-> ($past(state_ff) == dhc_pkg::ST_IDLE || $past(state_ff) == dhc_pkg::ST_MAP_RD || $past(state_ff) == dhc_pkg::ST_MAP_DIV))
   `DHC_ASSERT(a_vp_drop, clock, reset, (state_ff == dhc_pkg::ST_IDLE && $past(state_ff) == dhc_pkg::ST_IDLE) |-> $stable(vp_ff))
endmodule
`default_nettype wire
